### hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// A condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`endif

### hw/rtl/pcxr_pkg.sv
// Types, constants and register codes of the PCX run-length pixel decoder.
package pcxr_pkg;

    localparam int          MAX_LINE_BYTES_DEF = 256;
    localparam int          QUEUE_DEPTH        = 2;
    localparam logic [7:0]  RUN_BASE           = 8'd192;
    localparam logic [2:0]  MASK_ALPHA         = 3'd7;
    localparam logic [2:0]  MASK_PLAIN         = 3'd3;

    localparam logic [7:0]  IMAGE_WIDTH_RST    = 8'd255;
    localparam logic [7:0]  IMAGE_HEIGHT_RST   = 8'd255;
    localparam logic [8:0]  LINE_BYTES_RST     = 9'd256;
    localparam logic        ALPHA_MODE_RST     = 1'b0;

    typedef enum logic [3:0] {
        CFG_IMAGE_WIDTH  = 4'd0,
        CFG_IMAGE_HEIGHT = 4'd1,
        CFG_LINE_BYTES   = 4'd2,
        CFG_ALPHA_MODE   = 4'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] image_width;
        logic [7:0] image_height;
        logic [8:0] line_bytes;
        logic       alpha_mode;
    } cfg_t;

    // One visible stretch of pixels, all of one value, on one row.
    typedef struct packed {
        logic [2:0] value;
        logic [7:0] column;
        logic [7:0] row;
        logic [5:0] count;
    } cmd_t;

endpackage

### hw/rtl/pcxr_front.sv
// Front end: takes encoded bytes, tracks run and position state, issues pixel commands.
module pcxr_front #(
    parameter int MAX_LINE_BYTES = pcxr_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pcxr_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    output logic             push,
    output pcxr_pkg::cmd_t   push_cmd,
    input  logic             full
);
    import pcxr_pkg::*;

    // The line length register is nine bits wide, so the effective cap never exceeds 511.
    localparam int LB_CAP = (MAX_LINE_BYTES < 511) ? MAX_LINE_BYTES : 511;
    localparam int CW     = $clog2(LB_CAP);

    logic [5:0]    pending_reg, pending_next;
    logic [CW-1:0] column_reg, column_next;
    logic [7:0]    row_reg, row_next;

    logic          accept;
    logic          done;
    logic          is_marker;
    logic [5:0]    count;
    logic [7:0]    marker_diff;
    logic [8:0]    lb_eff;
    logic [8:0]    limit;
    logic [8:0]    col9;
    logic [8:0]    avail;
    logic [5:0]    n_pix;
    logic [9:0]    col_sum;
    logic [2:0]    mask;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    always_comb
    begin
        done        = (row_reg >= cfg.image_height);
        is_marker   = (pending_reg == 6'd0) && (data_byte > RUN_BASE);
        marker_diff = data_byte - RUN_BASE;
        count       = (pending_reg == 6'd0) ? 6'd1 : pending_reg;

        if (cfg.line_bytes == 9'd0)
        begin
            lb_eff = 9'd1;
        end
        else if ({1'b0, cfg.line_bytes} > 10'(LB_CAP))
        begin
            lb_eff = 9'(LB_CAP);
        end
        else
        begin
            lb_eff = cfg.line_bytes;
        end

        limit = ({1'b0, cfg.image_width} < lb_eff) ? {1'b0, cfg.image_width} : lb_eff;
        col9  = 9'(column_reg);
        avail = limit - col9;
        if (col9 >= limit)
        begin
            n_pix = 6'd0;
        end
        else if (avail < {3'b000, count})
        begin
            n_pix = avail[5:0];
        end
        else
        begin
            n_pix = count;
        end

        col_sum = {1'b0, col9} + {4'b0000, count};
        mask    = cfg.alpha_mode ? MASK_ALPHA : MASK_PLAIN;

        push           = accept && !done && !is_marker && (n_pix != 6'd0);
        push_cmd.value  = data_byte[2:0] & mask;
        push_cmd.column = col9[7:0];
        push_cmd.row    = row_reg;
        push_cmd.count  = n_pix;
    end

    always_comb
    begin
        pending_next = pending_reg;
        column_next  = column_reg;
        row_next     = row_reg;
        if (accept)
        begin
            priority if (done)
            begin
                pending_next = 6'd0;
            end
            else if (is_marker)
            begin
                pending_next = marker_diff[5:0];
            end
            else
            begin
                pending_next = 6'd0;
                if (col_sum >= {1'b0, lb_eff})
                begin
                    column_next = '0;
                    row_next    = row_reg + 8'd1;
                end
                else
                begin
                    column_next = col_sum[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 6'd0;
            column_reg  <= '0;
            row_reg     <= 8'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            column_reg  <= column_next;
            row_reg     <= row_next;
        end
    end

endmodule

### hw/rtl/pcxr_queue.sv
// Short command queue between the front end and the pixel emitter.
`include "assert_macros.svh"

module pcxr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pcxr_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output pcxr_pkg::cmd_t   head_cmd
);
    import pcxr_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_pop;

    assign full       = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, count_reg > QCW'(QUEUE_DEPTH))
    `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && full)

endmodule

### hw/rtl/pcxr_back.sv
// Back end: expands queued commands into one pixel word per cycle while out_ready is high.
`include "assert_macros.svh"

module pcxr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  pcxr_pkg::cmd_t   head_cmd,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       pixel_value,
    output logic [7:0]       pixel_column,
    output logic [7:0]       pixel_row,
    output logic             last_of_run
);
    import pcxr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [5:0] remain_reg, remain_next;
    logic [2:0] value_reg, value_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] row_reg, row_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !out_valid_reg || out_ready;
    assign pop  = load && (remain_reg == 6'd0) && head_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        remain_next    = remain_reg;
        value_next     = value_reg;
        column_next    = column_reg;
        row_next       = row_reg;
        last_next      = last_reg;
        if (load)
        begin
            priority if (remain_reg != 6'd0)
            begin
                out_valid_next = 1'b1;
                column_next    = column_reg + 8'd1;
                remain_next    = remain_reg - 6'd1;
                last_next      = (remain_reg == 6'd1);
            end
            else if (head_valid)
            begin
                out_valid_next = 1'b1;
                value_next     = head_cmd.value;
                column_next    = head_cmd.column;
                row_next       = head_cmd.row;
                remain_next    = head_cmd.count - 6'd1;
                last_next      = (head_cmd.count == 6'd1);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            remain_reg    <= 6'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        column_reg <= column_next;
        row_reg    <= row_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = value_reg;
    assign pixel_column = column_reg;
    assign pixel_row    = row_reg;
    assign last_of_run  = last_reg;

    `ASSERT_CLK(a_remain_implies_valid, clk, rst_n, (remain_reg != 6'd0) |-> out_valid_reg)
    `ASSERT_CLK(a_last_matches_remain, clk, rst_n,
        out_valid_reg |-> (last_reg == (remain_reg == 6'd0)))

endmodule

### hw/rtl/pcx_rle_pixel_decoder.sv
// Top level of the PCX run-length pixel decoder: configuration registers and the three stages.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------------
//  input    | in_valid / in_ready    | data_byte
//  output   | out_valid / out_ready  | pixel_value, pixel_column, pixel_row, last_of_run
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The front end takes one word per cycle while the command queue has room; a run marker
// or an ignored byte is taken the same way and yields nothing. The emitter drives one
// pixel word per cycle while out_ready is high, so the input rate is set by the emitter
// whenever runs are long. Reset clears run, column and row state, empties the queue and
// loads the register reset values; no clearing pass is needed. Either side may stall on
// its own: the queue and the output register decouple them.
module pcx_rle_pixel_decoder #(
    parameter int MAX_LINE_BYTES = pcxr_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] pixel_value,
    output logic [7:0] pixel_column,
    output logic [7:0] pixel_row,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [8:0] cfg_data
);
    import pcxr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Register writes are always accepted; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[7:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[7:0];
                CFG_LINE_BYTES:   cfg_next.line_bytes   = cfg_data;
                CFG_ALPHA_MODE:   cfg_next.alpha_mode   = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= IMAGE_WIDTH_RST;
            cfg_reg.image_height <= IMAGE_HEIGHT_RST;
            cfg_reg.line_bytes   <= LINE_BYTES_RST;
            cfg_reg.alpha_mode   <= ALPHA_MODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end classifies each byte and advances the position right away, since the
    // position depends only on counts; the visible part of each byte goes to the queue.
    pcxr_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full)
    );

    pcxr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The emitter walks each command one column per cycle while out_ready is high and flags its final pixel.
    pcxr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .last_of_run  (last_of_run)
    );

endmodule

### tb/pcx_rle_pixel_decoder_checker.sv
// Checker for the PCX run-length pixel decoder: watches all channels, predicts pixels, compares.
module pcx_rle_pixel_decoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] pixel_value,
    input  logic [7:0] pixel_column,
    input  logic [7:0] pixel_row,
    input  logic       last_of_run,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       finish_check,
    output int         fail_count,
    output int         pending_words,
    output int         pixels_checked,
    output logic [7:0] cur_row
);
    import pcxr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0] value;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];
    pixel_word_t head_px;

    // Shadow copy of the registers and of the decoder's position.
    cfg_t        shadow_cfg;
    logic [5:0]  run_left;
    int unsigned column_pos;
    logic [7:0]  row_pos;
    logic        closed;

    assign cur_row = row_pos;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] pixel mismatch: %s", $realtime, what);
    endtask

    function automatic int unsigned line_span();
        int unsigned lb;
        lb = 32'(shadow_cfg.line_bytes);
        if (lb == 0)
        begin
            lb = 1;
        end
        if (lb > MAX_LINE_BYTES_DEF)
        begin
            lb = MAX_LINE_BYTES_DEF;
        end
        return lb;
    endfunction

    // Expands one accepted data word into the pixels it must produce.
    task automatic decode_word(input logic [7:0] b);
        int unsigned span;
        int unsigned count;
        int unsigned limit;
        int unsigned col;
        int unsigned r;
        logic [2:0]  keep;
        pixel_word_t px;
        if (row_pos >= shadow_cfg.image_height)
        begin
            run_left = '0;
            return;
        end
        if (run_left == 0)
        begin
            if (b > RUN_BASE)
            begin
                run_left = 6'(b - RUN_BASE);
                return;
            end
            count = 1;
        end
        else
        begin
            count    = 32'(run_left);
            run_left = '0;
        end
        span  = line_span();
        limit = (32'(shadow_cfg.image_width) < span) ? 32'(shadow_cfg.image_width) : span;
        keep  = shadow_cfg.alpha_mode ? MASK_ALPHA : MASK_PLAIN;
        for (r = 0; r < count; r++)
        begin
            col = column_pos + r;
            if (col < limit)
            begin
                px.value  = b[2:0] & keep;
                px.column = col[7:0];
                px.row    = row_pos;
                px.last   = (r + 1 == count) || (col + 1 >= limit);
                expected_pixels.push_back(px);
            end
        end
        column_pos += count;
        if (column_pos >= span)
        begin
            column_pos = 0;
            row_pos    = row_pos + 8'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            shadow_cfg.image_width  = IMAGE_WIDTH_RST;
            shadow_cfg.image_height = IMAGE_HEIGHT_RST;
            shadow_cfg.line_bytes   = LINE_BYTES_RST;
            shadow_cfg.alpha_mode   = ALPHA_MODE_RST;
            run_left       = '0;
            column_pos     = 0;
            row_pos        = '0;
            closed         = 1'b0;
            fail_count     = 0;
            pixels_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                pixels_checked++;
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel value %0d row %0d column %0d",
                                              pixel_value, pixel_row, pixel_column));
                end
                else
                begin
                    head_px = expected_pixels.pop_front();
                    if (pixel_value !== head_px.value || pixel_column !== head_px.column ||
                        pixel_row !== head_px.row || last_of_run !== head_px.last)
                    begin
                        report_mismatch($sformatf(
                            "got v%0d c%0d r%0d l%0d, expected v%0d c%0d r%0d l%0d",
                            pixel_value, pixel_column, pixel_row, last_of_run,
                            head_px.value, head_px.column, head_px.row, head_px.last));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                decode_word(data_byte);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  shadow_cfg.image_width  = cfg_data[7:0];
                    CFG_IMAGE_HEIGHT: shadow_cfg.image_height = cfg_data[7:0];
                    CFG_LINE_BYTES:   shadow_cfg.line_bytes   = cfg_data;
                    CFG_ALPHA_MODE:   shadow_cfg.alpha_mode   = cfg_data[0];
                    default:          ;
                endcase
            end
            if (finish_check && !closed)
            begin
                closed = 1'b1;
                if (expected_pixels.size() != 0)
                begin
                    report_mismatch($sformatf("%0d expected pixels never arrived",
                                              expected_pixels.size()));
                end
            end
        end
        pending_words = expected_pixels.size();
    end

endmodule

### tb/pcx_rle_pixel_decoder_tb.sv
// Testbench top for the PCX run-length pixel decoder: clock, reset, stimulus and verdict.
module pcx_rle_pixel_decoder_tb;
    import pcxr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // The slowest legal run stays far below this; hitting it means the block hung.
    localparam int         CYCLE_LIMIT   = 600000;
    // The decoder holds at most a two-entry queue and an output register, so the settle
    // wait after the last pixel is enough for a swallowed marker to be gone too.
    localparam int         SETTLE_CYCLES = 8;
    localparam int         DRAIN_CYCLES  = 20;
    // Index past the register list; a write there must change nothing.
    localparam logic [3:0] CFG_NO_REG    = 4'd13;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte    = '0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [2:0] pixel_value;
    logic [7:0] pixel_column;
    logic [7:0] pixel_row;
    logic       last_of_run;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_index    = '0;
    logic [8:0] cfg_data     = '0;
    logic       finish_check = 1'b0;

    int          fail_count;
    int          pending_words;
    int          pixels_checked;
    logic [7:0]  cur_row;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          words_sent     = 0;
    int          settings_used  = 0;
    int unsigned cycle_count    = 0;

    pcx_rle_pixel_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_value  (pixel_value),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    pcx_rle_pixel_decoder_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_value    (pixel_value),
        .pixel_column   (pixel_column),
        .pixel_row      (pixel_row),
        .last_of_run    (last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .finish_check   (finish_check),
        .fail_count     (fail_count),
        .pending_words  (pending_words),
        .pixels_checked (pixels_checked),
        .cur_row        (cur_row)
    );

    always #10 clk = ~clk;

    // The pixel receiver stalls on a fresh coin flip every cycle, so stalls land on
    // every phase of a run expansion.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one data word and returns at the edge that accepts it. Valid is left
    // high so that a back-to-back word follows without a bubble; any idle cycles
    // drop it at the next falling edge first.
    task automatic send_word(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        words_sent++;
    endtask

    // Writes one register; only called while the decoder is idle.
    task automatic write_reg(input logic [3:0] idx, input logic [8:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender off until every predicted pixel has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Full quiet point before a register write: drained, then a settle wait so
    // that a marker or an ignored word still inside the block is gone.
    task automatic wait_quiet();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Rows only ever advance, so each phase grants a number of rows past the
    // current one; the height register runs out once they are used.
    function automatic logic [8:0] height_after(input int rows);
        int h;
        h = cur_row + rows;
        if (h > 255)
        begin
            h = 255;
        end
        return h[8:0];
    endfunction

    task automatic apply_setting(input logic [8:0] width, input logic [8:0] height,
                                 input logic [8:0] lbytes, input logic alpha);
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, width);
        write_reg(CFG_LINE_BYTES, lbytes);
        write_reg(CFG_ALPHA_MODE, {8'd0, alpha});
        write_reg(CFG_IMAGE_HEIGHT, height);
        settings_used++;
    endtask

    // Mostly well-formed marker and value pairs with random content, plus literals
    // and raw noise bytes. Halfway through, the sender stops until all pixels are out.
    task automatic random_phase(input int n_words);
        int         sent;
        int         pick;
        logic [7:0] mark;
        logic       paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_words)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                // Short runs dominate so the run stays quick; long ones still appear.
                if ($urandom_range(0, 3) == 0)
                begin
                    mark = RUN_BASE + 8'($urandom_range(1, 63));
                end
                else
                begin
                    mark = RUN_BASE + 8'($urandom_range(1, 6));
                end
                send_word(mark);
                send_word(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else if (pick < 8)
            begin
                send_word(8'($urandom_range(0, 192)));
                sent++;
            end
            else
            begin
                send_word(8'($urandom_range(0, 255)));
                sent++;
            end
            if (!paused && sent >= n_words / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        // First idle mix: sender idles a little, receiver a lot.
        send_idle_pct = 27;
        recv_idle_pct = 85;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: literals at both ends of the literal range, including 192 which
        // is a literal and not a marker, a single-pixel run, a 63-pixel run whose value
        // looks like a marker, and runs that fill the 256-position row exactly.
        send_word(8'h00);
        send_word(8'hC0);
        send_word(8'hBF);
        send_word(8'hC1);
        send_word(8'hFF);
        send_word(8'hFF);
        send_word(8'hC5);
        send_word(8'hE0);
        send_word(8'h02);
        send_word(8'hFF);
        send_word(8'h01);
        send_word(8'hFF);
        send_word(8'h02);
        send_word(8'hDF);
        send_word(8'h03);

        // Narrow image with padding, three-bit pixels, and only three rows left.
        // The write to an unused index must leave everything as it is.
        wait_quiet();
        write_reg(CFG_ALPHA_MODE, 9'd1);
        write_reg(CFG_IMAGE_WIDTH, 9'd6);
        write_reg(CFG_LINE_BYTES, 9'd10);
        write_reg(CFG_IMAGE_HEIGHT, height_after(3));
        write_reg(CFG_NO_REG, 9'h1FF);
        settings_used++;
        // A literal, then a run clipped at the width.
        send_word(8'h05);
        send_word(8'hC8);
        send_word(8'hFE);
        // A run lying wholly in the padding, which closes the row.
        send_word(8'hC4);
        send_word(8'h03);
        // A run crossing the row end, then a literal with the alpha bit set.
        send_word(8'hFF);
        send_word(8'h01);
        send_word(8'h0F);
        // This run uses up the last row; the marker and value after it are ignored.
        send_word(8'hFF);
        send_word(8'h09);
        send_word(8'hD0);
        send_word(8'h04);

        // Random phases under the first idle mix: reset-like geometry, then the
        // narrowest image where every pixel word ends a row.
        apply_setting(9'd255, height_after(20), 9'd256, 1'b0);
        random_phase(35);
        apply_setting(9'd1, height_after(15), 9'd1, 1'b1);
        random_phase(30);

        // Second idle mix: sender idles a lot, receiver a little.
        send_idle_pct = 85;
        recv_idle_pct = 27;
        // Zero width emits nothing; an oversized line length is clamped.
        apply_setting(9'd0, height_after(10), 9'd300, 1'b0);
        random_phase(20);
        // Line length below the width.
        apply_setting(9'd200, height_after(30), 9'd100, 1'b1);
        random_phase(35);
        // Zero line length behaves as one position per row.
        apply_setting(9'd37, height_after(8), 9'd0, 1'b0);
        random_phase(15);
        // Zero height: every word is ignored.
        apply_setting(9'd37, 9'd0, 9'd64, 1'b0);
        random_phase(8);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(9'd255, 9'd255, 9'd511, 1'b1);
        random_phase(35);
        apply_setting(9'd128, height_after(20), 9'd129, 1'b0);
        random_phase(30);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        finish_check <= 1'b1;
        repeat (2) @(negedge clk);

        $display("Summary: %0d data words in, %0d pixel words checked over %0d settings,",
                 words_sent, pixels_checked, settings_used);
        $display("Summary: two skewed idle mixes and a stretch at full rate were exercised.");
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### pcx_rle_pixel_decoder.f
+incdir+hw/rtl
hw/rtl/pcxr_pkg.sv
hw/rtl/pcxr_front.sv
hw/rtl/pcxr_queue.sv
hw/rtl/pcxr_back.sv
hw/rtl/pcx_rle_pixel_decoder.sv
tb/pcx_rle_pixel_decoder_checker.sv
tb/pcx_rle_pixel_decoder_tb.sv
